/* rtl/line_pixel_stepper_macros.svh */
// Assertion macros for the line pixel stepper.
// Used by the RTL files that carry concurrent checks; clock i_clk, reset i_rst_n.
`ifndef LINE_PIXEL_STEPPER_MACROS_SVH
`define LINE_PIXEL_STEPPER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define LPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define LPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lps_pkg.sv */
// Shared types and constants of the line pixel stepper.
// No dependencies; used by lps_addr and line_pixel_stepper.
package lps_pkg;

    // coordinate width and the widths derived from it
    localparam int COORD_BITS = 12;
    localparam int SPAN_W     = COORD_BITS;
    localparam int NSPAN_W    = COORD_BITS + 1;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int ERR_W      = COORD_BITS + 2;
    localparam int E2_W       = COORD_BITS + 3;

    // fixed field widths
    localparam int SCR_W      = 13;
    localparam int ROWB_W     = 15;
    localparam int BPP_W      = 3;
    localparam int OFF_W      = 26;
    localparam int COLOR_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // stream packing
    localparam int IN_DATA_BITS  = 4 * COORD_BITS + COLOR_W;
    localparam int IN_DATA_W     = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = 2 * COORD_BITS + OFF_W + COLOR_W;
    localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_USER_W    = 2;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [NSPAN_W-1:0]    t_nspan;
    typedef logic        [SPAN_W-1:0]     t_span;
    typedef logic signed [ERR_W-1:0]      t_err;
    typedef logic signed [E2_W-1:0]       t_e2;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH    = 2'd0,
        CFG_SCREEN_HEIGHT   = 2'd1,
        CFG_ROW_BYTES       = 2'd2,
        CFG_BYTES_PER_PIXEL = 2'd3
    } t_cfg_idx;

    // register reset values
    localparam logic [SCR_W-1:0]  RST_SCREEN_WIDTH  = 13'd1920;
    localparam logic [SCR_W-1:0]  RST_SCREEN_HEIGHT = 13'd1080;
    localparam logic [ROWB_W-1:0] RST_ROW_BYTES     = 15'd7680;
    localparam logic [BPP_W-1:0]  RST_BPP           = 3'd4;

    typedef struct packed {
        logic [SCR_W-1:0]  screen_width;
        logic [SCR_W-1:0]  screen_height;
        logic [ROWB_W-1:0] row_bytes;
        logic [BPP_W-1:0]  bytes_per_pixel;
    } t_cfg;

endpackage

/* rtl/lps_addr.sv */
// Screen clipping and framebuffer byte offset of one pixel.
// Depends on lps_pkg; instantiated by line_pixel_stepper.
module lps_addr (
    input  lps_pkg::t_cfg                i_cfg,
    input  lps_pkg::t_coord              i_x,
    input  lps_pkg::t_coord              i_y,
    output logic                         o_visible,
    output logic [lps_pkg::OFF_W-1:0]    o_offset
);

    logic [lps_pkg::COORD_BITS-1:0] ux;
    logic [lps_pkg::COORD_BITS-1:0] uy;
    logic [lps_pkg::OFF_W-1:0]      x_ext;
    logic [lps_pkg::OFF_W-1:0]      y_ext;
    logic [lps_pkg::OFF_W-1:0]      rb_ext;
    logic [lps_pkg::OFF_W-1:0]      bpp_ext;
    logic [lps_pkg::OFF_W-1:0]      row_part;
    logic [lps_pkg::OFF_W-1:0]      col_part;

    assign ux = i_x;
    assign uy = i_y;

    // negative coordinates are off screen
    assign o_visible = !i_x[lps_pkg::COORD_BITS-1] && !i_y[lps_pkg::COORD_BITS-1]
                    && (ux < i_cfg.screen_width) && (uy < i_cfg.screen_height);

    // y * row_bytes + x * bytes_per_pixel, wrapping at the offset width
    assign x_ext    = lps_pkg::OFF_W'(ux);
    assign y_ext    = lps_pkg::OFF_W'(uy);
    assign rb_ext   = lps_pkg::OFF_W'(i_cfg.row_bytes);
    assign bpp_ext  = lps_pkg::OFF_W'(i_cfg.bytes_per_pixel);
    assign row_part = y_ext * rb_ext;
    assign col_part = x_ext * bpp_ext;
    assign o_offset = o_visible ? (row_part + col_part) : '0;

endmodule

/* rtl/line_pixel_stepper.sv */
// Bresenham line rasterizer, top level: command stream in, pixel stream out.
// Depends on lps_pkg, lps_addr and line_pixel_stepper_macros.svh.
//
// A load request latches two signed endpoints and a color and returns the first
// pixel; each step request returns the next pixel of the line with its clip flag,
// framebuffer byte offset and last flag, and a step with no line in progress
// returns an empty result (tuser pixel_valid 0, tlast 1). One request is taken
// every clock while the pixel stream keeps up, and each gives exactly one result:
// the accepting edge updates the Bresenham state (error compare, two adds and the
// endpoint test), and the clip test and the y*row_bytes + x*bytes_per_pixel
// multiply are registered into the output register when it is free to load.
// The request side stalls only while both the state stage and the output register
// hold a pixel that the pixel stream has not taken. Both ready outputs are low
// during reset. Configuration writes are only to be made while the block is idle;
// the block itself does not enforce this.
`include "line_pixel_stepper_macros.svh"

module line_pixel_stepper (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lps_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lps_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // request stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: start_x, start_y, end_x, end_y, start_color
    input  logic [lps_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // tuser: command
    input  logic                                 s_axis_tuser,
    // pixel stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: pixel_x, pixel_y, byte_offset, pixel_color, zero fill
    output logic [lps_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // tuser: pixel_valid, visible
    output logic [lps_pkg::OUT_USER_W-1:0]       m_axis_tuser,
    output logic                                 m_axis_tlast
);

    localparam int CB = lps_pkg::COORD_BITS;

    // configuration
    lps_pkg::t_cfg r_cfg;

    // line state
    lps_pkg::t_coord r_cur_x, n_cur_x;
    lps_pkg::t_coord r_cur_y, n_cur_y;
    lps_pkg::t_coord r_tgt_x, n_tgt_x;
    lps_pkg::t_coord r_tgt_y, n_tgt_y;
    lps_pkg::t_span  r_span_x, n_span_x;
    lps_pkg::t_nspan r_nspan_y, n_nspan_y;
    lps_pkg::t_err   r_err, n_err;
    logic            r_step_left, n_step_left;
    logic            r_step_up, n_step_up;
    logic [lps_pkg::COLOR_W-1:0] r_color, n_color;
    logic            r_active, n_active;

    // stage one flags
    logic r_s1_valid;
    logic r_s1_pix, n_pix;
    logic r_s1_last, n_last;

    // result register
    logic                          r_o_valid;
    logic                          r_o_pix;
    logic                          r_o_vis;
    logic                          r_o_last;
    lps_pkg::t_coord               r_o_x;
    lps_pkg::t_coord               r_o_y;
    logic [lps_pkg::OFF_W-1:0]     r_o_off;
    logic [lps_pkg::COLOR_W-1:0]   r_o_color;

    // handshake
    logic out_load;
    logic in_acc;

    // unpacked request
    lps_pkg::t_cmd               in_cmd;
    lps_pkg::t_coord             in_x0, in_y0, in_x1, in_y1;
    logic [lps_pkg::COLOR_W-1:0] in_color;

    // load arithmetic
    lps_pkg::t_diff dx, dy, adx;

    // step arithmetic
    lps_pkg::t_e2 st_e2, st_nsy, st_sx;
    lps_pkg::t_err st_add_x, st_add_y;
    logic st_mv_x, st_mv_y;

    // endpoint test on the next state
    lps_pkg::t_e2 ln_e2, ln_nsy, ln_sx;

    // clip and address of the pixel in stage one
    logic                      a_vis;
    logic [lps_pkg::OFF_W-1:0] a_off;

    assign o_cfg_ready   = i_rst_n;
    assign out_load      = !r_o_valid || m_axis_tready;
    assign s_axis_tready = i_rst_n && (!r_s1_valid || out_load);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign in_cmd   = lps_pkg::t_cmd'(s_axis_tuser);
    assign in_x0    = s_axis_tdata[CB-1:0];
    assign in_y0    = s_axis_tdata[2*CB-1:CB];
    assign in_x1    = s_axis_tdata[3*CB-1:2*CB];
    assign in_y1    = s_axis_tdata[4*CB-1:3*CB];
    assign in_color = s_axis_tdata[4*CB+lps_pkg::COLOR_W-1:4*CB];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width    <= lps_pkg::RST_SCREEN_WIDTH;
            r_cfg.screen_height   <= lps_pkg::RST_SCREEN_HEIGHT;
            r_cfg.row_bytes       <= lps_pkg::RST_ROW_BYTES;
            r_cfg.bytes_per_pixel <= lps_pkg::RST_BPP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (lps_pkg::t_cfg_idx'(i_cfg_index))
                lps_pkg::CFG_SCREEN_WIDTH: begin
                    r_cfg.screen_width <= i_cfg_data[lps_pkg::SCR_W-1:0];
                end
                lps_pkg::CFG_SCREEN_HEIGHT: begin
                    r_cfg.screen_height <= i_cfg_data[lps_pkg::SCR_W-1:0];
                end
                lps_pkg::CFG_ROW_BYTES: begin
                    r_cfg.row_bytes <= i_cfg_data[lps_pkg::ROWB_W-1:0];
                end
                lps_pkg::CFG_BYTES_PER_PIXEL: begin
                    r_cfg.bytes_per_pixel <= i_cfg_data[lps_pkg::BPP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // load: spans, directions and initial error
    assign dx  = lps_pkg::t_diff'(in_x1) - lps_pkg::t_diff'(in_x0);
    assign dy  = lps_pkg::t_diff'(in_y1) - lps_pkg::t_diff'(in_y0);
    assign adx = dx[lps_pkg::DIFF_W-1] ? -dx : dx;

    // step: Bresenham move decision on the current error
    assign st_e2    = lps_pkg::t_e2'({r_err, 1'b0});
    assign st_nsy   = lps_pkg::t_e2'(r_nspan_y);
    assign st_sx    = lps_pkg::t_e2'({1'b0, r_span_x});
    assign st_mv_x  = (st_e2 >= st_nsy);
    assign st_mv_y  = (st_e2 <= st_sx);
    assign st_add_x = st_mv_x ? lps_pkg::t_err'(r_nspan_y) : '0;
    assign st_add_y = st_mv_y ? lps_pkg::t_err'({1'b0, r_span_x}) : '0;

    // next state and the endpoint flag of the pixel it gives
    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_tgt_x     = r_tgt_x;
        n_tgt_y     = r_tgt_y;
        n_span_x    = r_span_x;
        n_nspan_y   = r_nspan_y;
        n_err       = r_err;
        n_step_left = r_step_left;
        n_step_up   = r_step_up;
        n_color     = r_color;
        n_pix       = 1'b1;
        case (in_cmd)
            lps_pkg::CMD_LOAD: begin
                n_cur_x     = in_x0;
                n_cur_y     = in_y0;
                n_tgt_x     = in_x1;
                n_tgt_y     = in_y1;
                n_step_left = !(in_x0 < in_x1);
                n_step_up   = !(in_y0 < in_y1);
                n_span_x    = adx[lps_pkg::SPAN_W-1:0];
                n_nspan_y   = dy[lps_pkg::DIFF_W-1] ? dy : -dy;
                n_err       = lps_pkg::t_err'({1'b0, n_span_x}) + lps_pkg::t_err'(n_nspan_y);
                n_color     = in_color;
            end
            lps_pkg::CMD_STEP: begin
                if (r_active) begin
                    n_err = r_err + st_add_x + st_add_y;
                    if (st_mv_x) begin
                        n_cur_x = r_step_left ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
                    end
                    if (st_mv_y) begin
                        n_cur_y = r_step_up ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
                    end
                end else begin
                    n_pix = 1'b0;
                end
            end
            default: begin
                n_pix = 1'b0;
            end
        endcase
    end

    // endpoint, or the axis about to move already sits at its end
    assign ln_e2  = lps_pkg::t_e2'({n_err, 1'b0});
    assign ln_nsy = lps_pkg::t_e2'(n_nspan_y);
    assign ln_sx  = lps_pkg::t_e2'({1'b0, n_span_x});

    always_comb begin
        if (!n_pix) begin
            n_last   = 1'b1;
            n_active = r_active;
        end else begin
            n_last = ((n_cur_x == n_tgt_x) && (n_cur_y == n_tgt_y))
                  || ((ln_e2 >= ln_nsy) && (n_cur_x == n_tgt_x))
                  || ((ln_e2 <= ln_sx) && (n_cur_y == n_tgt_y));
            n_active = !n_last;
        end
    end

    // state update on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_tgt_x     <= '0;
            r_tgt_y     <= '0;
            r_span_x    <= '0;
            r_nspan_y   <= '0;
            r_err       <= '0;
            r_step_left <= 1'b0;
            r_step_up   <= 1'b0;
            r_color     <= '0;
            r_active    <= 1'b0;
        end else if (in_acc) begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_tgt_x     <= n_tgt_x;
            r_tgt_y     <= n_tgt_y;
            r_span_x    <= n_span_x;
            r_nspan_y   <= n_nspan_y;
            r_err       <= n_err;
            r_step_left <= n_step_left;
            r_step_up   <= n_step_up;
            r_color     <= n_color;
            r_active    <= n_active;
        end
    end

    // stage one valid and flags; the pixel itself is the state above
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_pix   <= 1'b0;
            r_s1_last  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                r_s1_pix   <= n_pix;
                r_s1_last  <= n_last;
            end else if (out_load) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // clip test and byte offset of the stage one pixel
    lps_addr u_addr (
        .i_cfg     (r_cfg),
        .i_x       (r_cur_x),
        .i_y       (r_cur_y),
        .o_visible (a_vis),
        .o_offset  (a_off)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_o_pix   <= r_s1_pix;
            r_o_last  <= r_s1_last;
            r_o_vis   <= r_s1_pix && a_vis;
            r_o_x     <= r_s1_pix ? r_cur_x : '0;
            r_o_y     <= r_s1_pix ? r_cur_y : '0;
            r_o_off   <= r_s1_pix ? a_off : '0;
            r_o_color <= r_s1_pix ? r_color : '0;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = lps_pkg::OUT_DATA_W'({r_o_color, r_o_off, r_o_y, r_o_x});
    assign m_axis_tuser  = {r_o_vis, r_o_pix};
    assign m_axis_tlast  = r_o_last;

    // checks
    `LPS_ASSERT_NOW(a_s1_active_tracks_last, r_s1_valid && r_s1_pix, r_active == !r_s1_last, "active flag disagrees with last flag of newest pixel")
    `LPS_ASSERT_NEXT(a_idle_step_keeps_idle, in_acc && (in_cmd == lps_pkg::CMD_STEP) && !r_active, !r_active && !r_s1_pix, "step without a line changed the state")
    `LPS_ASSERT_NOW(a_empty_result_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast && (m_axis_tdata == '0) && !m_axis_tuser[1], "empty result carries data")
    `LPS_ASSERT_NOW(a_hidden_offset_zero, m_axis_tvalid && !m_axis_tuser[1], m_axis_tdata[lps_pkg::OFF_W+2*CB-1:2*CB] == '0, "offset set on a pixel that is not visible")

endmodule

/* bench/line_pixel_stepper_tb.sv */
// Self-checking bench for line_pixel_stepper: random line commands in, pixels checked out.
// Depends on lps_pkg and the line_pixel_stepper RTL; a scoreboard class tracks the lines.
`timescale 1ns / 1ps

module line_pixel_stepper_tb;

    localparam int DRAIN_CYCLES   = 6;    // slack for the pipe to settle after the last owed pixel
    localparam int RX_HOLD_CYCLES = 300;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 215;
    localparam int CDW            = lps_pkg::CFG_DATA_W;

    // one pixel result, fields unsigned so compares never sign-extend
    typedef struct packed {
        logic                        pixel_valid;
        logic                        visible;
        logic [11:0]                 x;
        logic [11:0]                 y;
        logic [lps_pkg::OFF_W-1:0]   offset;
        logic [lps_pkg::COLOR_W-1:0] color;
        logic                        is_last;
    } t_pixel;

    // Scoreboard: mirrors the Bresenham state and holds the pixels still owed
    class pixel_scoreboard;
        int unsigned scr_w, scr_h, row_b, bpp;
        int          cur_x, cur_y, tgt_x, tgt_y, span_x, nspan_y, err;
        bit          go_left, go_up, busy;
        logic [31:0] color;
        t_pixel      pending_pixels[$];
        int          errors;

        function new();
            scr_w   = 32'(lps_pkg::RST_SCREEN_WIDTH);
            scr_h   = 32'(lps_pkg::RST_SCREEN_HEIGHT);
            row_b   = 32'(lps_pkg::RST_ROW_BYTES);
            bpp     = 32'(lps_pkg::RST_BPP);
            cur_x   = 0;
            cur_y   = 0;
            tgt_x   = 0;
            tgt_y   = 0;
            span_x  = 0;
            nspan_y = 0;
            err     = 0;
            go_left = 0;
            go_up   = 0;
            busy    = 0;
            color   = '0;
            errors  = 0;
        endfunction

        function void set_reg(lps_pkg::t_cfg_idx idx, logic [CDW-1:0] v);
            case (idx)
                lps_pkg::CFG_SCREEN_WIDTH:    scr_w = 32'(v[lps_pkg::SCR_W-1:0]);
                lps_pkg::CFG_SCREEN_HEIGHT:   scr_h = 32'(v[lps_pkg::SCR_W-1:0]);
                lps_pkg::CFG_ROW_BYTES:       row_b = 32'(v[lps_pkg::ROWB_W-1:0]);
                lps_pkg::CFG_BYTES_PER_PIXEL: bpp   = 32'(v[lps_pkg::BPP_W-1:0]);
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        // pixel at the current position; also decides whether the line ends here
        function t_pixel trace_pixel();
            t_pixel      p;
            int          e2;
            bit          vis;
            logic [31:0] off;
            e2 = 2 * err;
            p.is_last = (cur_x == tgt_x && cur_y == tgt_y) ||
                        (e2 >= nspan_y && cur_x == tgt_x) ||
                        (e2 <= span_x && cur_y == tgt_y);
            busy = !p.is_last;
            vis = cur_x >= 0 && cur_y >= 0 && cur_x < int'(scr_w) && cur_y < int'(scr_h);
            off = vis ? cur_y * int'(row_b) + cur_x * int'(bpp) : 0;
            p.pixel_valid = 1'b1;
            p.visible     = vis;
            p.x           = cur_x[11:0];
            p.y           = cur_y[11:0];
            p.offset      = off[lps_pkg::OFF_W-1:0];
            p.color       = color;
            return p;
        endfunction

        function void note_request(lps_pkg::t_cmd cmd, lps_pkg::t_coord sx,
                                   lps_pkg::t_coord sy, lps_pkg::t_coord ex,
                                   lps_pkg::t_coord ey, logic [31:0] c);
            int     e2;
            t_pixel p;
            if (cmd == lps_pkg::CMD_LOAD) begin
                cur_x   = int'(sx);
                cur_y   = int'(sy);
                tgt_x   = int'(ex);
                tgt_y   = int'(ey);
                go_left = !(cur_x < tgt_x);
                go_up   = !(cur_y < tgt_y);
                span_x  = tgt_x >= cur_x ? tgt_x - cur_x : cur_x - tgt_x;
                nspan_y = tgt_y >= cur_y ? cur_y - tgt_y : tgt_y - cur_y;
                err     = span_x + nspan_y;
                color   = c;
                pending_pixels.push_back(trace_pixel());
            end else if (!busy) begin
                // step with no line in progress: empty result flagged last
                p = '0;
                p.is_last = 1'b1;
                pending_pixels.push_back(p);
            end else begin
                e2 = 2 * err;
                if (e2 >= nspan_y) begin
                    err   += nspan_y;
                    cur_x += go_left ? -1 : 1;
                end
                if (e2 <= span_x) begin
                    err   += span_x;
                    cur_y += go_up ? -1 : 1;
                end
                pending_pixels.push_back(trace_pixel());
            end
        endfunction

        function void match_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(logic [lps_pkg::OUT_DATA_W-1:0] data,
                                  logic [lps_pkg::OUT_USER_W-1:0] user, logic tl);
            t_pixel p;
            if (pending_pixels.size() == 0) begin
                $error("pixel result with no request outstanding");
                errors++;
                return;
            end
            p = pending_pixels.pop_front();
            match_field("pixel_valid", 32'(p.pixel_valid), 32'(user[0]));
            match_field("visible", 32'(p.visible), 32'(user[1]));
            match_field("pixel_x", 32'(p.x), 32'(data[11:0]));
            match_field("pixel_y", 32'(p.y), 32'(data[23:12]));
            match_field("byte_offset", 32'(p.offset), 32'(data[49:24]));
            match_field("pixel_color", p.color, data[81:50]);
            match_field("last", 32'(p.is_last), 32'(tl));
        endfunction
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [lps_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [CDW-1:0]                    i_cfg_data;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [lps_pkg::IN_DATA_W-1:0]     s_axis_tdata;
    logic                              s_axis_tuser;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [lps_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
    logic [lps_pkg::OUT_USER_W-1:0]    m_axis_tuser;
    logic                              m_axis_tlast;

    pixel_scoreboard sb;
    bit tx_burst;
    bit rx_burst;
    bit rx_hold;

    line_pixel_stepper u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("line_pixel_stepper regression: fail");
        $finish;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pixel(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // result side: random stalls, bursts, and one long hold-off on request
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 10);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // one request; the scoreboard is told at the accepting edge
    task automatic send_request(input lps_pkg::t_cmd cmd, input lps_pkg::t_coord sx,
                                input lps_pkg::t_coord sy, input lps_pkg::t_coord ex,
                                input lps_pkg::t_coord ey, input logic [31:0] c);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {c, ey, ex, sy, sx};    // 80 bits, no fill
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(cmd, sx, sy, ex, ey, c);
    endtask

    function automatic lps_pkg::t_coord any_coord();
        logic [31:0] r;
        r = $urandom();
        return r[11:0];
    endfunction

    function automatic lps_pkg::t_coord clamp_coord(int v);
        if (v < -2048)
            return -12'sd2048;
        if (v > 2047)
            return 12'sd2047;
        return v[11:0];
    endfunction

    // coordinate mostly around the visible area, sometimes anywhere or at the rails
    function automatic lps_pkg::t_coord pick_coord(int unsigned dim);
        case ($urandom_range(0, 9))
            6, 7:    return any_coord();
            8:       return $urandom_range(0, 1) ? 12'sd2047 : -12'sd2048;
            9:       return clamp_coord(int'($urandom_range(0, 8)) - 4);
            default: return clamp_coord(int'($urandom_range(0, dim + 16)) - 8);
        endcase
    endfunction

    // step request; the coordinate and color fields carry ignored noise
    task automatic send_step();
        send_request(lps_pkg::CMD_STEP, any_coord(), any_coord(), any_coord(), any_coord(),
                     $urandom());
    endtask

    task automatic load_and_step(input lps_pkg::t_coord sx, input lps_pkg::t_coord sy,
                                 input lps_pkg::t_coord ex, input lps_pkg::t_coord ey,
                                 input logic [31:0] c, input int steps);
        send_request(lps_pkg::CMD_LOAD, sx, sy, ex, ey, c);
        repeat (steps) send_step();
    endtask

    // stop offering, wait for every owed pixel, then let the pipe settle
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CDW-1:0] w, input logic [CDW-1:0] h,
                                input logic [CDW-1:0] rb, input logic [CDW-1:0] bp);
        lps_pkg::t_cfg_idx regs[4];
        logic [CDW-1:0]    vals[4];
        regs = '{lps_pkg::CFG_SCREEN_WIDTH, lps_pkg::CFG_SCREEN_HEIGHT,
                 lps_pkg::CFG_ROW_BYTES, lps_pkg::CFG_BYTES_PER_PIXEL};
        vals = '{w, h, rb, bp};
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_reg(regs[i], vals[i]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // extremes, idle step, single point, clip edges, flat, vertical and steep lines
    task automatic run_directed();
        send_step();
        load_and_step(-12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047, 32'hFFFF_FFFF, 1);
        load_and_step(12'sd2047, 12'sd2047, -12'sd2048, -12'sd2048, 32'h0000_0000, 1);
        load_and_step(12'sd5, 12'sd5, 12'sd5, 12'sd5, 32'h1234_5678, 1);
        load_and_step(12'sd1919, 12'sd1079, 12'sd1921, 12'sd1081, 32'hA5A5_5A5A, 2);
        load_and_step(12'sd3, -12'sd1, 12'sd0, -12'sd1, 32'h0F0F_F0F0, 3);
        load_and_step(12'sd0, 12'sd2, 12'sd0, -12'sd1, 32'h8000_0001, 3);
        load_and_step(12'sd0, 12'sd0, 12'sd1, 12'sd3, 32'h7FFF_FFFE, 4);
    endtask

    // one random sequence; returns how many requests it took
    task automatic random_sequence(output int count);
        lps_pkg::t_coord sx, sy, ex, ey;
        int              reach, kind, n;
        count = 0;
        kind  = $urandom_range(0, 19);
        if (kind == 0) begin
            // noise: any command, any data
            send_request($urandom_range(0, 1) ? lps_pkg::CMD_STEP : lps_pkg::CMD_LOAD,
                         any_coord(), any_coord(), any_coord(), any_coord(), $urandom());
            count = 1;
            return;
        end
        reach = ($urandom_range(0, 39) == 0) ? 300 : 16;
        sx = pick_coord(sb.scr_w);
        sy = pick_coord(sb.scr_h);
        ex = clamp_coord(int'(sx) + int'($urandom_range(0, 2 * reach)) - reach);
        ey = clamp_coord(int'(sy) + int'($urandom_range(0, 2 * reach)) - reach);
        send_request(lps_pkg::CMD_LOAD, sx, sy, ex, ey, $urandom());
        count++;
        if (kind <= 2) begin
            // broken line: a few steps, then the next load cuts it short
            n = $urandom_range(0, 3);
            while (sb.busy && n > 0) begin
                send_step();
                count++;
                n--;
            end
            return;
        end
        while (sb.busy) begin
            send_step();
            count++;
        end
        // occasional steps past the end
        if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 3);
            repeat (n) send_step();
            count += n;
        end
    endtask

    // main sequence
    initial begin
        int done, count;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        tx_burst      = 1'b0;
        rx_burst      = 1'b0;
        rx_hold       = 1'b0;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_block();
            case (ph)
                0: write_config(15'd4096, 15'd4096, 15'd16384, 15'd4);
                1: write_config(15'd0, 15'd0, 15'd0, 15'd1);
                2: write_config(15'd64, 15'd48, 15'd256, 15'd2);
                3, 4: write_config(CDW'($urandom()), CDW'($urandom()), CDW'($urandom()),
                                   CDW'($urandom()));
                default: write_config(CDW'(lps_pkg::RST_SCREEN_WIDTH),
                                      CDW'(lps_pkg::RST_SCREEN_HEIGHT),
                                      CDW'(lps_pkg::RST_ROW_BYTES),
                                      CDW'(lps_pkg::RST_BPP));
            endcase
            // long result stall while requests keep coming
            if (ph == 2)
                rx_hold = 1'b1;
            done = 0;
            while (done < PHASE_ITEMS) begin
                random_sequence(count);
                done += count;
            end
        end

        drain_block();
        if (sb.errors == 0)
            $display("line_pixel_stepper regression: pass");
        else
            $display("line_pixel_stepper regression: fail");
        $finish;
    end

endmodule
